/* src/pcs_pkg.sv */
`timescale 1ns / 1ps

package pcs_pkg;

    localparam int SAMPLES_MAX_DEF = 512;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FIELD_W         = 24;
    localparam int CORR_W          = 16;
    localparam int ROOT_SHIFT      = 30;
    localparam int ACC_STEPS       = 6;

    // product index: 0..17 are nine pairs, then A*B, N*N, then the root search
    localparam int PI_W    = 5;
    localparam int PI_AB   = 18;
    localparam int PI_RHS  = 19;
    localparam int PI_ROOT = 20;

    localparam int PAIR_VX  = 0;
    localparam int PAIR_VY  = 1;
    localparam int PAIR_VT  = 2;
    localparam int PAIR_CXY = 3;
    localparam int PAIR_CXT = 4;
    localparam int PAIR_CYT = 5;
    localparam int PAIR_A   = 6;
    localparam int PAIR_B   = 7;
    localparam int PAIR_N   = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_CHECK,
        S_LOAD,
        S_MUL,
        S_STORE,
        S_COMB,
        S_DONE
    } pcs_state_t;

    typedef struct packed {
        logic               sample_valid;
        logic [FIELD_W-1:0] price_sample;
        logic [FIELD_W-1:0] volume_sample;
        logic               row_last;
    } sample_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] partial_corr;
        logic                     corr_valid;
    } result_t;

endpackage

/* src/pcs_mul.sv */
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// done is high once the remaining multiplier bits are all zero.
module pcs_mul #(
    parameter int MC_W = 8,
    parameter int MP_W = 8,
    parameter int P_W  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  logic [MC_W-1:0] mcand,
    input  logic [MP_W-1:0] mplier,
    output logic [P_W-1:0]  prod,
    output logic            done
);

    logic [P_W-1:0]  mcand_reg, mcand_next;
    logic [MP_W-1:0] mplier_reg, mplier_next;
    logic [P_W-1:0]  prod_reg, prod_next;

    always_comb
    begin
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (load)
        begin
            mcand_next  = P_W'(mcand);
            mplier_next = mplier;
            prod_next   = '0;
        end
        else if (mplier_reg != '0)
        begin
            if (mplier_reg[0])
            begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mplier_reg <= '0;
        end
        else
        begin
            mplier_reg <= mplier_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        prod_reg  <= prod_next;
    end

    assign prod = prod_reg;
    assign done = (mplier_reg == '0);

endmodule

/* src/partial_correlation_streaming.sv */
`timescale 1ns / 1ps

// Partial correlation of price and volume with time held fixed, one row of
// samples per result. A sample transaction is taken when start is high and
// busy is low. A valid sample keeps the block busy after it is taken while six
// products pass through one small multiplier into the running sums; a missing
// sample, or one past SAMPLES_MAX, leaves it idle unless it ends the row.
// After the row's last sample, if over two samples were valid, the block works
// out the exact integer result with one bit-serial shift-add multiplier: 20
// wide products, each worked one multiplier bit per cycle until its remaining
// multiplier bits are zero, then 16 square-root steps, each one more product.
// A variance or denominator that is not positive ends it early. The result
// appears on result for exactly one cycle with done high and must be taken
// then; the receiver cannot stall it. The block is ready again the next cycle.
module partial_correlation_streaming
    import pcs_pkg::*;
#(
    parameter int SAMPLES_MAX = SAMPLES_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  sample_t sample,
    output logic    busy,
    output result_t result,
    output logic    done
);

    localparam int CNT_W = $clog2(SAMPLES_MAX + 1);
    localparam int SX_W  = SAMPLE_BITS + CNT_W;
    localparam int ST_W  = 2 * CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;
    localparam int STT_W = 3 * CNT_W;
    localparam int SXT_W = SAMPLE_BITS + 2 * CNT_W;
    localparam int OP_W  = (SAMPLE_BITS > CNT_W) ? SAMPLE_BITS : CNT_W;
    localparam int MW    = (2 * SAMPLE_BITS + 2 * CNT_W > 4 * CNT_W) ?
                           2 * SAMPLE_BITS + 2 * CNT_W : 4 * CNT_W;
    localparam int FW    = 2 * MW;
    localparam int NW    = FW + 1;
    localparam int MC_W  = 2 * NW;
    localparam int MP_W  = NW;
    localparam int P_W   = MC_W + 2 * CORR_W;
    localparam int BIT_W = $clog2(CORR_W);

    pcs_state_t state_reg, state_next;

    logic [CNT_W-1:0] time_index_reg, time_index_next;
    logic [CNT_W-1:0] valid_count_reg, valid_count_next;
    logic [SX_W-1:0]  sum_price_reg, sum_price_next;
    logic [SX_W-1:0]  sum_volume_reg, sum_volume_next;
    logic [ST_W-1:0]  sum_time_reg, sum_time_next;
    logic [SQ_W-1:0]  sum_price_sq_reg, sum_price_sq_next;
    logic [SQ_W-1:0]  sum_volume_sq_reg, sum_volume_sq_next;
    logic [STT_W-1:0] sum_time_sq_reg, sum_time_sq_next;
    logic [SQ_W-1:0]  sum_price_volume_reg, sum_price_volume_next;
    logic [SXT_W-1:0] sum_price_time_reg, sum_price_time_next;
    logic [SXT_W-1:0] sum_volume_time_reg, sum_volume_time_next;
    logic             last_reg, last_next;
    logic [2:0]       acc_step_reg, acc_step_next;
    logic [PI_W-1:0]  pi_reg, pi_next;
    logic [BIT_W-1:0] bit_reg, bit_next;
    logic             ok_reg, ok_next;

    logic [OP_W-1:0]   x_reg, x_next;
    logic [OP_W-1:0]   y_reg, y_next;
    logic [OP_W-1:0]   t_reg, t_next;
    logic [2*OP_W-1:0] accp_reg, accp_next;
    logic [FW-1:0]     first_reg, first_next;
    logic              neg_reg, neg_next;
    logic [MW-1:0]     vx_reg, vx_next;
    logic [MW-1:0]     vy_reg, vy_next;
    logic [MW-1:0]     vt_reg, vt_next;
    logic [MW-1:0]     cxy_reg, cxy_next;
    logic [MW-1:0]     cxt_reg, cxt_next;
    logic [MW-1:0]     cyt_reg, cyt_next;
    logic              sgn_xy_reg, sgn_xy_next;
    logic              sgn_xt_reg, sgn_xt_next;
    logic              sgn_yt_reg, sgn_yt_next;
    logic [FW-1:0]     a_reg, a_next;
    logic [FW-1:0]     b_reg, b_next;
    logic [NW-1:0]     num_reg, num_next;
    logic              sneg_reg, sneg_next;
    logic [MC_W-1:0]   ab_reg, ab_next;
    logic [P_W-1:0]    rhs_reg, rhs_next;
    logic [CORR_W-1:0] q_reg, q_next;

    logic              accept;
    logic [OP_W-1:0]   ma, mb;
    logic              mul_load;
    logic [MC_W-1:0]   mcand_sel;
    logic [MP_W-1:0]   mplier_sel;
    logic [P_W-1:0]    prod;
    logic              mul_done;
    logic [FW-1:0]     prodf;
    logic [PI_W-2:0]   pair;
    logic [CORR_W-1:0] k_val;
    logic [2*CORR_W-1:0] kk;
    logic              s2neg;
    logic              add_sel;
    logic [NW-1:0]     comb_val;
    logic              v_pair;
    logic [CORR_W:0]   q_ext, mag, val, lim_pos, lim_neg;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);
    assign prodf  = prod[FW-1:0];
    assign pair   = pi_reg[PI_W-1:1];
    assign k_val  = q_reg | (CORR_W'(1) << bit_reg);
    assign kk     = k_val * k_val;
    assign s2neg  = !(sgn_xt_reg ^ sgn_yt_reg);
    assign add_sel = (pair == (PI_W-1)'(PAIR_N)) && (sgn_xy_reg == s2neg);
    assign v_pair = (pair == (PI_W-1)'(PAIR_VX)) || (pair == (PI_W-1)'(PAIR_VY)) ||
                    (pair == (PI_W-1)'(PAIR_VT)) || (pair == (PI_W-1)'(PAIR_A)) ||
                    (pair == (PI_W-1)'(PAIR_B));

    always_comb
    begin
        if (add_sel)
        begin
            comb_val = NW'(first_reg) + NW'(prodf);
        end
        else if (neg_reg)
        begin
            comb_val = NW'(prodf) - NW'(first_reg);
        end
        else
        begin
            comb_val = NW'(first_reg) - NW'(prodf);
        end
    end

    // accumulate-step multiplier operands
    always_comb
    begin
        case (acc_step_reg)
            3'd0:    begin ma = x_reg; mb = x_reg; end
            3'd1:    begin ma = y_reg; mb = y_reg; end
            3'd2:    begin ma = t_reg; mb = t_reg; end
            3'd3:    begin ma = x_reg; mb = y_reg; end
            3'd4:    begin ma = x_reg; mb = t_reg; end
            3'd5:    begin ma = y_reg; mb = t_reg; end
            default: begin ma = '0;    mb = '0;    end
        endcase
    end

    // operands of the shared multiplier for each product index
    always_comb
    begin
        case (pi_reg)
            5'd0:    begin mcand_sel = MC_W'(sum_price_sq_reg);     mplier_sel = MP_W'(valid_count_reg); end
            5'd1:    begin mcand_sel = MC_W'(sum_price_reg);        mplier_sel = MP_W'(sum_price_reg);   end
            5'd2:    begin mcand_sel = MC_W'(sum_volume_sq_reg);    mplier_sel = MP_W'(valid_count_reg); end
            5'd3:    begin mcand_sel = MC_W'(sum_volume_reg);       mplier_sel = MP_W'(sum_volume_reg);  end
            5'd4:    begin mcand_sel = MC_W'(sum_time_sq_reg);      mplier_sel = MP_W'(valid_count_reg); end
            5'd5:    begin mcand_sel = MC_W'(sum_time_reg);         mplier_sel = MP_W'(sum_time_reg);    end
            5'd6:    begin mcand_sel = MC_W'(sum_price_volume_reg); mplier_sel = MP_W'(valid_count_reg); end
            5'd7:    begin mcand_sel = MC_W'(sum_price_reg);        mplier_sel = MP_W'(sum_volume_reg);  end
            5'd8:    begin mcand_sel = MC_W'(sum_price_time_reg);   mplier_sel = MP_W'(valid_count_reg); end
            5'd9:    begin mcand_sel = MC_W'(sum_price_reg);        mplier_sel = MP_W'(sum_time_reg);    end
            5'd10:   begin mcand_sel = MC_W'(sum_volume_time_reg);  mplier_sel = MP_W'(valid_count_reg); end
            5'd11:   begin mcand_sel = MC_W'(sum_volume_reg);       mplier_sel = MP_W'(sum_time_reg);    end
            5'd12:   begin mcand_sel = MC_W'(vx_reg);  mplier_sel = MP_W'(vt_reg);  end
            5'd13:   begin mcand_sel = MC_W'(cxt_reg); mplier_sel = MP_W'(cxt_reg); end
            5'd14:   begin mcand_sel = MC_W'(vy_reg);  mplier_sel = MP_W'(vt_reg);  end
            5'd15:   begin mcand_sel = MC_W'(cyt_reg); mplier_sel = MP_W'(cyt_reg); end
            5'd16:   begin mcand_sel = MC_W'(cxy_reg); mplier_sel = MP_W'(vt_reg);  end
            5'd17:   begin mcand_sel = MC_W'(cxt_reg); mplier_sel = MP_W'(cyt_reg); end
            5'd18:   begin mcand_sel = MC_W'(a_reg);   mplier_sel = MP_W'(b_reg);   end
            5'd19:   begin mcand_sel = MC_W'(num_reg); mplier_sel = MP_W'(num_reg); end
            default: begin mcand_sel = ab_reg;         mplier_sel = MP_W'(kk);      end
        endcase
    end

    pcs_mul #(
        .MC_W (MC_W),
        .MP_W (MP_W),
        .P_W  (P_W)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (mul_load),
        .mcand  (mcand_sel),
        .mplier (mplier_sel),
        .prod   (prod),
        .done   (mul_done)
    );

    always_comb
    begin
        state_next            = state_reg;
        time_index_next       = time_index_reg;
        valid_count_next      = valid_count_reg;
        sum_price_next        = sum_price_reg;
        sum_volume_next       = sum_volume_reg;
        sum_time_next         = sum_time_reg;
        sum_price_sq_next     = sum_price_sq_reg;
        sum_volume_sq_next    = sum_volume_sq_reg;
        sum_time_sq_next      = sum_time_sq_reg;
        sum_price_volume_next = sum_price_volume_reg;
        sum_price_time_next   = sum_price_time_reg;
        sum_volume_time_next  = sum_volume_time_reg;
        last_next             = last_reg;
        acc_step_next         = acc_step_reg;
        pi_next               = pi_reg;
        bit_next              = bit_reg;
        ok_next               = ok_reg;
        x_next                = x_reg;
        y_next                = y_reg;
        t_next                = t_reg;
        accp_next             = accp_reg;
        first_next            = first_reg;
        neg_next              = neg_reg;
        vx_next               = vx_reg;
        vy_next               = vy_reg;
        vt_next               = vt_reg;
        cxy_next              = cxy_reg;
        cxt_next              = cxt_reg;
        cyt_next              = cyt_reg;
        sgn_xy_next           = sgn_xy_reg;
        sgn_xt_next           = sgn_xt_reg;
        sgn_yt_next           = sgn_yt_reg;
        a_next                = a_reg;
        b_next                = b_reg;
        num_next              = num_reg;
        sneg_next             = sneg_reg;
        ab_next               = ab_reg;
        rhs_next              = rhs_reg;
        q_next                = q_reg;
        mul_load              = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    last_next = sample.row_last;
                    if (time_index_reg < CNT_W'(SAMPLES_MAX))
                    begin
                        time_index_next = time_index_reg + 1'b1;
                        if (sample.sample_valid)
                        begin
                            x_next = OP_W'(sample.price_sample[SAMPLE_BITS-1:0]);
                            y_next = OP_W'(sample.volume_sample[SAMPLE_BITS-1:0]);
                            t_next = OP_W'(time_index_reg);
                            sum_price_next  = sum_price_reg +
                                              SX_W'(sample.price_sample[SAMPLE_BITS-1:0]);
                            sum_volume_next = sum_volume_reg +
                                              SX_W'(sample.volume_sample[SAMPLE_BITS-1:0]);
                            sum_time_next    = sum_time_reg + ST_W'(time_index_reg);
                            valid_count_next = valid_count_reg + 1'b1;
                            acc_step_next    = '0;
                            state_next       = S_ACC;
                        end
                        else if (sample.row_last)
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else if (sample.row_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end

            S_ACC:
            begin
                // product of step k is registered, added to its sum at step k+1
                accp_next = ma * mb;
                case (acc_step_reg)
                    3'd1: sum_price_sq_next     = sum_price_sq_reg + SQ_W'(accp_reg);
                    3'd2: sum_volume_sq_next    = sum_volume_sq_reg + SQ_W'(accp_reg);
                    3'd3: sum_time_sq_next      = sum_time_sq_reg + STT_W'(accp_reg);
                    3'd4: sum_price_volume_next = sum_price_volume_reg + SQ_W'(accp_reg);
                    3'd5: sum_price_time_next   = sum_price_time_reg + SXT_W'(accp_reg);
                    3'd6: sum_volume_time_next  = sum_volume_time_reg + SXT_W'(accp_reg);
                    default: ;
                endcase
                acc_step_next = acc_step_reg + 1'b1;
                if (acc_step_reg == 3'(ACC_STEPS))
                begin
                    state_next = last_reg ? S_CHECK : S_IDLE;
                end
            end

            S_CHECK:
            begin
                pi_next = '0;
                if (valid_count_reg <= CNT_W'(2))
                begin
                    ok_next    = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ok_next    = 1'b1;
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                mul_load   = 1'b1;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                if (mul_done)
                begin
                    state_next = S_STORE;
                end
            end

            S_STORE:
            begin
                if (pi_reg == PI_W'(PI_ROOT))
                begin
                    if (prod <= rhs_reg)
                    begin
                        q_next = k_val;
                    end
                    if (bit_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else if (pi_reg == PI_W'(PI_RHS))
                begin
                    rhs_next   = prod << ROOT_SHIFT;
                    pi_next    = PI_W'(PI_ROOT);
                    bit_next   = BIT_W'(CORR_W - 1);
                    q_next     = '0;
                    state_next = S_LOAD;
                end
                else if (pi_reg == PI_W'(PI_AB))
                begin
                    ab_next    = prod[MC_W-1:0];
                    pi_next    = pi_reg + 1'b1;
                    state_next = S_LOAD;
                end
                else if (!pi_reg[0])
                begin
                    first_next = prodf;
                    pi_next    = pi_reg + 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    neg_next = (first_reg < prodf);
                    // a variance or denominator that is not positive ends the row
                    if (v_pair && (first_reg <= prodf))
                    begin
                        ok_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_COMB;
                    end
                end
            end

            S_COMB:
            begin
                case (pair)
                    (PI_W-1)'(PAIR_VX):  vx_next = comb_val[MW-1:0];
                    (PI_W-1)'(PAIR_VY):  vy_next = comb_val[MW-1:0];
                    (PI_W-1)'(PAIR_VT):  vt_next = comb_val[MW-1:0];
                    (PI_W-1)'(PAIR_CXY):
                    begin
                        cxy_next    = comb_val[MW-1:0];
                        sgn_xy_next = neg_reg;
                    end
                    (PI_W-1)'(PAIR_CXT):
                    begin
                        cxt_next    = comb_val[MW-1:0];
                        sgn_xt_next = neg_reg;
                    end
                    (PI_W-1)'(PAIR_CYT):
                    begin
                        cyt_next    = comb_val[MW-1:0];
                        sgn_yt_next = neg_reg;
                    end
                    (PI_W-1)'(PAIR_A):   a_next = comb_val[FW-1:0];
                    (PI_W-1)'(PAIR_B):   b_next = comb_val[FW-1:0];
                    (PI_W-1)'(PAIR_N):
                    begin
                        num_next  = comb_val;
                        sneg_next = (add_sel || !neg_reg) ? sgn_xy_reg : s2neg;
                    end
                    default: ;
                endcase
                pi_next    = pi_reg + 1'b1;
                state_next = S_LOAD;
            end

            S_DONE:
            begin
                time_index_next       = '0;
                valid_count_next      = '0;
                sum_price_next        = '0;
                sum_volume_next       = '0;
                sum_time_next         = '0;
                sum_price_sq_next     = '0;
                sum_volume_sq_next    = '0;
                sum_time_sq_next      = '0;
                sum_price_volume_next = '0;
                sum_price_time_next   = '0;
                sum_volume_time_next  = '0;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            time_index_reg       <= '0;
            valid_count_reg      <= '0;
            sum_price_reg        <= '0;
            sum_volume_reg       <= '0;
            sum_time_reg         <= '0;
            sum_price_sq_reg     <= '0;
            sum_volume_sq_reg    <= '0;
            sum_time_sq_reg      <= '0;
            sum_price_volume_reg <= '0;
            sum_price_time_reg   <= '0;
            sum_volume_time_reg  <= '0;
            last_reg             <= 1'b0;
            acc_step_reg         <= '0;
            pi_reg               <= '0;
            bit_reg              <= '0;
            ok_reg               <= 1'b0;
        end
        else
        begin
            state_reg            <= state_next;
            time_index_reg       <= time_index_next;
            valid_count_reg      <= valid_count_next;
            sum_price_reg        <= sum_price_next;
            sum_volume_reg       <= sum_volume_next;
            sum_time_reg         <= sum_time_next;
            sum_price_sq_reg     <= sum_price_sq_next;
            sum_volume_sq_reg    <= sum_volume_sq_next;
            sum_time_sq_reg      <= sum_time_sq_next;
            sum_price_volume_reg <= sum_price_volume_next;
            sum_price_time_reg   <= sum_price_time_next;
            sum_volume_time_reg  <= sum_volume_time_next;
            last_reg             <= last_next;
            acc_step_reg         <= acc_step_next;
            pi_reg               <= pi_next;
            bit_reg              <= bit_next;
            ok_reg               <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        t_reg      <= t_next;
        accp_reg   <= accp_next;
        first_reg  <= first_next;
        neg_reg    <= neg_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        vt_reg     <= vt_next;
        cxy_reg    <= cxy_next;
        cxt_reg    <= cxt_next;
        cyt_reg    <= cyt_next;
        sgn_xy_reg <= sgn_xy_next;
        sgn_xt_reg <= sgn_xt_next;
        sgn_yt_reg <= sgn_yt_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        num_reg    <= num_next;
        sneg_reg   <= sneg_next;
        ab_reg     <= ab_next;
        rhs_reg    <= rhs_next;
        q_reg      <= q_next;
    end

    // saturate: +32767 on the positive side, -32768 on the negative side
    always_comb
    begin
        q_ext   = {1'b0, q_reg};
        lim_pos = (CORR_W+1)'((2 ** (CORR_W - 1)) - 1);
        lim_neg = (CORR_W+1)'(2 ** (CORR_W - 1));
        if (sneg_reg)
        begin
            mag = (q_ext > lim_neg) ? lim_neg : q_ext;
            val = -mag;
        end
        else
        begin
            mag = (q_ext > lim_pos) ? lim_pos : q_ext;
            val = mag;
        end
    end

    assign done              = (state_reg == S_DONE);
    assign result.corr_valid = ok_reg;
    assign result.partial_corr = ok_reg ? $signed(val[CORR_W-1:0]) : '0;

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sample.row_last) |=> !done)
        else $error("result without row end");

    a_few_samples_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (valid_count_reg <= CNT_W'(2))) |-> !result.corr_valid)
        else $error("result valid with too few samples");

    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!busy && (valid_count_reg == '0) && (time_index_reg == '0)))
        else $error("row state not cleared after result");

    a_time_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (time_index_reg <= CNT_W'(SAMPLES_MAX)) && (valid_count_reg <= time_index_reg))
        else $error("sample position out of range");

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import pcs_pkg::*;

    localparam int  ROW_SPAN    = 512;
    localparam int  ITEMS_GOAL  = 1150;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef logic signed [511:0] wide_t;

    class corr_scoreboard;
        result_t   pending_q[$];
        int        errors;
        int        rows_seen;
        int        rows_invalid;
        bit [63:0] pos, cnt, sx, sy, st, sxx, syy, stt, sxy, sxt, syt;

        function new();
            errors = 0;
            rows_seen = 0;
            rows_invalid = 0;
            clear_row();
        endfunction

        function void clear_row();
            pos = 0; cnt = 0; sx = 0; sy = 0; st = 0;
            sxx = 0; syy = 0; stt = 0; sxy = 0; sxt = 0; syt = 0;
        endfunction

        function wide_t moment(bit [63:0] n, bit [63:0] s2, bit [63:0] sa, bit [63:0] sb);
            wide_t wn, w2, wa, wb;
            wn = n; w2 = s2; wa = sa; wb = sb;
            return wn * w2 - wa * wb;
        endfunction

        // exact partial correlation from the integer sums
        function result_t row_corr();
            result_t r;
            wide_t vx, vy, vt, cxy, cxt, cyt, a, b, num, mag, rhs, lhs, kk;
            bit [31:0] q, k;
            r.partial_corr = '0;
            r.corr_valid = 1'b0;
            if (cnt <= 2)
                return r;
            vx = moment(cnt, sxx, sx, sx);
            vy = moment(cnt, syy, sy, sy);
            vt = moment(cnt, stt, st, st);
            if (vx <= 0 || vy <= 0 || vt <= 0)
                return r;
            cxy = moment(cnt, sxy, sx, sy);
            cxt = moment(cnt, sxt, sx, st);
            cyt = moment(cnt, syt, sy, st);
            a = vx * vt - cxt * cxt;
            b = vy * vt - cyt * cyt;
            if (a <= 0 || b <= 0)
                return r;
            num = cxy * vt - cxt * cyt;
            mag = (num < 0) ? -num : num;
            rhs = (mag * mag) <<< 30;
            q = 0;
            for (int bt = 15; bt >= 0; bt--)
            begin
                k = q | (32'd1 << bt);
                kk = k;
                lhs = kk * kk * a * b;
                if (lhs <= rhs)
                    q = k;
            end
            if (num < 0)
            begin
                if (q > 32768) q = 32768;
                r.partial_corr = -$signed(q[16:0]);
            end
            else
            begin
                if (q > 32767) q = 32767;
                r.partial_corr = q[15:0];
            end
            r.corr_valid = 1'b1;
            return r;
        endfunction

        function void note(sample_t s);
            bit [63:0] x, y;
            result_t r;
            x = s.price_sample;
            y = s.volume_sample;
            if (pos < ROW_SPAN)
            begin
                if (s.sample_valid)
                begin
                    sx += x; sy += y; st += pos;
                    sxx += x * x; syy += y * y; stt += pos * pos;
                    sxy += x * y; sxt += x * pos; syt += y * pos;
                    cnt++;
                end
                pos++;
            end
            if (s.row_last)
            begin
                r = row_corr();
                pending_q.push_back(r);
                rows_seen++;
                if (!r.corr_valid)
                    rows_invalid++;
                clear_row();
            end
        endfunction

        function void check(result_t got);
            result_t want;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: partial_corr=%0d corr_valid=%0b",
                       got.partial_corr, got.corr_valid);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.partial_corr !== want.partial_corr)
            begin
                $error("partial_corr: expected %0d, actual %0d",
                       want.partial_corr, got.partial_corr);
                errors++;
            end
            if (got.corr_valid !== want.corr_valid)
            begin
                $error("corr_valid: expected %0b, actual %0b",
                       want.corr_valid, got.corr_valid);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    sample_t sample;
    logic    busy;
    result_t result;
    logic    done;

    corr_scoreboard sb;
    int      items_sent;
    bit      allow_idle;
    longint  cycles;

    partial_correlation_streaming dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (sample),
        .busy   (busy),
        .result (result),
        .done   (done)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // start stays high after a transaction so the next one can follow at once
    task automatic send(input bit v, input bit [23:0] x, input bit [23:0] y,
                        input bit last);
        bit taken;
        taken = 0;
        if (allow_idle)
        begin
            while ($urandom_range(99) < 37)
            begin
                @(negedge clk);
                start = 1'b0;
                sample = $urandom;
            end
        end
        @(negedge clk);
        start = 1'b1;
        sample.sample_valid = v;
        sample.price_sample = x;
        sample.volume_sample = y;
        sample.row_last = last;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        sb.note(sample);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    // one row of random content; style picks how price and volume relate
    task automatic send_row(input int len, input int style);
        bit [23:0] x, y;
        bit v;
        for (int i = 0; i < len; i++)
        begin
            x = $urandom;
            y = $urandom;
            case (style)
                1: y = x + $urandom_range(0, 2000);
                2: y = 24'hFFFFFF - x;
                3: begin x = $urandom_range(0, 255); y = $urandom_range(0, 255); end
                4: x = 24'd777;
                5: begin x = i * 1000 + $urandom_range(0, 50); y = 5 * x; end
                default: ;
            endcase
            v = ($urandom_range(99) >= 15);
            send(v, x, y, i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        sb = new();
        items_sent = 0;
        cycles = 0;
        allow_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        sample = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // too few samples
        send(1, 24'd5, 24'd9, 1);
        // constant price
        send(1, 24'd100, 24'd1, 0);
        send(1, 24'd100, 24'd7, 0);
        send(1, 24'd100, 24'd3, 1);
        // identical price and volume, correlation of one, then mirrored, minus one
        send(1, 24'd10, 24'd10, 0);
        send(1, 24'd400, 24'd400, 0);
        send(1, 24'd20, 24'd20, 0);
        send(1, 24'd9000, 24'd9000, 1);
        send(1, 24'd10, 24'hFFFFF5, 0);
        send(1, 24'd400, 24'hFFFE6F, 0);
        send(1, 24'd20, 24'hFFFFEB, 0);
        send(1, 24'd9000, 24'hFFDCD7, 1);
        // field extremes with a missing sample
        send(1, 24'hFFFFFF, 24'd0, 0);
        send(0, 24'hABCDEF, 24'h123456, 0);
        send(1, 24'd0, 24'hFFFFFF, 0);
        send(1, 24'hFFFFFF, 24'hFFFFFF, 0);
        send(1, 24'd0, 24'd0, 0);
        send(1, 24'h800000, 24'h7FFFFF, 1);
        // row with nothing present
        send(0, 24'd1, 24'd2, 0);
        send(0, 24'd3, 24'd4, 1);

        allow_idle = 1'b1;
        for (int row = 0; items_sent < ITEMS_GOAL; row++)
        begin
            allow_idle = !(row >= 20 && row < 35);
            if (row == 10)
            begin
                send_row(ROW_SPAN + 6, 0);
                continue;
            end
            if (row == 6 || row == 40)
                wait_drained();
            len = ($urandom_range(99) < 8) ? $urandom_range(1, 3) : $urandom_range(3, 14);
            send_row(len, $urandom_range(0, 6));
        end

        wait_drained();
        repeat (50) @(posedge clk);
        $display("Covered %0d samples in %0d rows, %0d of them undefined.",
                 items_sent, sb.rows_seen, sb.rows_invalid);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
src/pcs_pkg.sv
src/pcs_mul.sv
src/partial_correlation_streaming.sv
dv/tb.sv
